>>> src/sci_pkg.sv
// Shared types, constants and helpers for the section crossing interpolator.
// No dependencies; every other file refers to it by scoped names.
package sci_pkg;

    // data word width and derived widths of the serial multiply/divide unit
    localparam int DW  = 32;
    localparam int PW  = 2 * DW + 1;
    localparam int SCW = $clog2(PW + 1);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_DETECT_X = 3'd0;
    localparam logic [2:0] CFG_DETECT_Y = 3'd1;
    localparam logic [2:0] CFG_MIRROR   = 3'd2;
    localparam logic [2:0] CFG_ABS_POS  = 3'd3;
    localparam logic [2:0] CFG_ABS_VEL  = 3'd4;

    // interpolation operations of one crossing, in issue order
    localparam logic [1:0] OP_TIME = 2'd0;
    localparam logic [1:0] OP_POS  = 2'd1;
    localparam logic [1:0] OP_VEL  = 2'd2;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic detect_x;
        logic detect_y;
        logic mirror;
        logic abs_pos;
        logic abs_vel;
    } t_cfg;

    // one classified sample pair: previous and current sample plus decisions
    typedef struct packed {
        logic signed [DW-1:0] t0;
        logic signed [DW-1:0] t1;
        logic signed [DW-1:0] x0;
        logic signed [DW-1:0] x1;
        logic signed [DW-1:0] y0;
        logic signed [DW-1:0] y1;
        logic signed [DW-1:0] u0;
        logic signed [DW-1:0] u1;
        logic signed [DW-1:0] v0;
        logic signed [DW-1:0] v1;
        logic                 keep_x;
        logic                 keep_y;
        logic                 neg_x;
        logic                 neg_y;
    } t_job;

    typedef enum logic [1:0] {
        IU_IDLE,
        IU_MUL,
        IU_DIV,
        IU_DONE
    } t_iu_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_START,
        BK_WAIT,
        BK_OUT
    } t_bk_state;

    // negation saturating the most negative value
    function automatic logic signed [DW-1:0] sat_neg(input logic signed [DW-1:0] v);
        sat_neg = (v == DMIN) ? DMAX : -v;
    endfunction

    function automatic logic signed [DW-1:0] sat_abs(input logic signed [DW-1:0] v);
        sat_abs = v[DW-1] ? sat_neg(v) : v;
    endfunction

endpackage

>>> src/sci_queue.sv
// Two-entry word queue between the classifying front and the interpolating back.
// Depends on sci_pkg (t_job, queue depth constants).
module sci_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sci_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sci_pkg::t_job o_job
);

    sci_pkg::t_job r_mem [sci_pkg::QDEPTH];
    logic [sci_pkg::QAW-1:0] r_wr_ptr;
    logic [sci_pkg::QAW-1:0] r_rd_ptr;
    logic [sci_pkg::QCW-1:0] r_count;

    assign o_full  = (r_count == sci_pkg::QCW'(sci_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + sci_pkg::QCW'(i_push) - sci_pkg::QCW'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sci_pkg::QCW'(sci_pkg::QDEPTH)) else $error("queue count overflow");
`endif

endmodule

>>> src/sci_front.sv
// Front end: accepts samples, holds the previous one and classifies crossings.
// Depends on sci_pkg; feeds sci_queue.
module sci_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sci_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_orbit_start,
    input  logic signed [sci_pkg::DW-1:0] i_sample_time,
    input  logic signed [sci_pkg::DW-1:0] i_pos_x,
    input  logic signed [sci_pkg::DW-1:0] i_pos_y,
    input  logic signed [sci_pkg::DW-1:0] i_vel_x,
    input  logic signed [sci_pkg::DW-1:0] i_vel_y,
    input  logic                        i_q_full,
    output logic                        o_push,
    output sci_pkg::t_job               o_job
);

    logic signed [sci_pkg::DW-1:0] r_prev_time, r_prev_px, r_prev_py, r_prev_vx, r_prev_vy;
    logic r_have_prev;
    logic accept, test, cross_x, cross_y, wrong_x, wrong_y;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign test    = !i_orbit_start && r_have_prev;

    // strict sign changes and wrong-direction flags
    always_comb begin
        cross_x = i_cfg.detect_x && test &&
                  ((r_prev_px[sci_pkg::DW-1] && !i_pos_x[sci_pkg::DW-1] && i_pos_x != '0) ||
                   (!r_prev_px[sci_pkg::DW-1] && r_prev_px != '0 && i_pos_x[sci_pkg::DW-1]));
        cross_y = i_cfg.detect_y && test &&
                  ((r_prev_py[sci_pkg::DW-1] && !i_pos_y[sci_pkg::DW-1] && i_pos_y != '0) ||
                   (!r_prev_py[sci_pkg::DW-1] && r_prev_py != '0 && i_pos_y[sci_pkg::DW-1]));
        wrong_x = !r_prev_vx[sci_pkg::DW-1] && (r_prev_vx != '0);
        wrong_y = r_prev_vy[sci_pkg::DW-1];
    end

    // job word
    always_comb begin
        o_job.t0     = r_prev_time;
        o_job.t1     = i_sample_time;
        o_job.x0     = r_prev_px;
        o_job.x1     = i_pos_x;
        o_job.y0     = r_prev_py;
        o_job.y1     = i_pos_y;
        o_job.u0     = r_prev_vx;
        o_job.u1     = i_vel_x;
        o_job.v0     = r_prev_vy;
        o_job.v1     = i_vel_y;
        o_job.keep_x = cross_x && (!wrong_x || i_cfg.mirror);
        o_job.keep_y = cross_y && (!wrong_y || i_cfg.mirror);
        o_job.neg_x  = wrong_x && i_cfg.mirror;
        o_job.neg_y  = wrong_y && i_cfg.mirror;
    end

    assign o_push = accept && (o_job.keep_x || o_job.keep_y);

    // previous sample
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_time <= i_sample_time;
            r_prev_px   <= i_pos_x;
            r_prev_py   <= i_pos_y;
            r_prev_vx   <= i_vel_x;
            r_prev_vy   <= i_vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (accept) begin
            r_have_prev <= 1'b1;
        end
    end

endmodule

>>> src/sci_interp.sv
// Bit-serial interpolation unit: a0 + sign * round(|a1-a0| * |c0| / |c1-c0|).
// Shift-add multiply then restoring divide, one bit a cycle. Depends on sci_pkg.
module sci_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [sci_pkg::DW-1:0] i_a0,
    input  logic signed [sci_pkg::DW-1:0] i_a1,
    input  logic signed [sci_pkg::DW-1:0] i_c0,
    input  logic signed [sci_pkg::DW-1:0] i_c1,
    output logic                          o_done,
    output logic signed [sci_pkg::DW-1:0] o_result
);

    localparam int DW  = sci_pkg::DW;
    localparam int PW  = sci_pkg::PW;
    localparam int SCW = sci_pkg::SCW;

    sci_pkg::t_iu_state r_state, n_state;
    logic [SCW-1:0]   r_step;
    logic [PW-1:0]    r_prod;
    logic [DW+1:0]    r_rem;
    logic [DW-1:0]    r_p;
    logic [DW:0]      r_q;
    logic [DW-1:0]    r_a0;
    logic             r_neg;

    logic signed [DW:0] delta, qd;
    logic [DW:0]   mdelta, mq;
    logic [DW-1:0] mp;
    logic [DW:0]   sum;
    logic [DW+1:0] tmp;
    logic          ge, rnd;
    logic [DW:0]   quo;
    logic [DW+1:0] res;
    logic          last_step;

    // operand preparation at start
    always_comb begin
        delta  = {i_a1[DW-1], i_a1} - {i_a0[DW-1], i_a0};
        mdelta = delta[DW] ? (DW+1)'(-delta) : delta;
        mp     = i_c0[DW-1] ? -i_c0 : i_c0;
        qd     = {i_c1[DW-1], i_c1} - {i_c0[DW-1], i_c0};
        mq     = qd[DW] ? (DW+1)'(-qd) : qd;
    end

    // one multiply step, one divide step, final rounding
    always_comb begin
        sum = {1'b0, r_prod[PW-1:DW+1]} + (r_prod[0] ? {1'b0, r_p} : '0);
        tmp = {r_rem[DW:0], r_prod[PW-1]};
        ge  = (tmp >= {1'b0, r_q});
        rnd = ({r_rem[DW:0], 1'b0} >= {1'b0, r_q});
        quo = r_prod[DW:0] + (DW+1)'(rnd);
        res = r_neg ? {{2{r_a0[DW-1]}}, r_a0} - {1'b0, quo}
                    : {{2{r_a0[DW-1]}}, r_a0} + {1'b0, quo};
    end

    always_comb begin
        last_step = 1'b0;
        case (r_state)
            sci_pkg::IU_MUL: last_step = (r_step == SCW'(DW));
            sci_pkg::IU_DIV: last_step = (r_step == SCW'(PW - 1));
            default:         last_step = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sci_pkg::IU_IDLE: if (i_start) n_state = sci_pkg::IU_MUL;
            sci_pkg::IU_MUL:  if (last_step) n_state = sci_pkg::IU_DIV;
            sci_pkg::IU_DIV:  if (last_step) n_state = sci_pkg::IU_DONE;
            sci_pkg::IU_DONE: n_state = sci_pkg::IU_IDLE;
            default:          n_state = sci_pkg::IU_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done   = 1'b0;
        o_result = res[DW-1:0];
        case (r_state)
            sci_pkg::IU_DONE: o_done = 1'b1;
            default:          o_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sci_pkg::IU_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (last_step || r_state == sci_pkg::IU_IDLE) ? '0 : r_step + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            sci_pkg::IU_IDLE: begin
                if (i_start) begin
                    r_prod <= {{DW{1'b0}}, mdelta};
                    r_p    <= mp;
                    r_q    <= mq;
                    r_a0   <= i_a0;
                    r_neg  <= delta[DW];
                    r_rem  <= '0;
                end
            end
            sci_pkg::IU_MUL: r_prod <= {sum, r_prod[DW:1]};
            sci_pkg::IU_DIV: begin
                r_rem  <= ge ? tmp - {1'b0, r_q} : tmp;
                r_prod <= {r_prod[PW-2:0], ge};
            end
            default: ;
        endcase
    end

endmodule

>>> src/sci_back.sv
// Back end: runs the interpolations of each queued job and presents results.
// Depends on sci_pkg and sci_interp.
module sci_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sci_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_valid,
    input  sci_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_crossing_index,
    output logic signed [sci_pkg::DW-1:0] o_crossing_time,
    output logic signed [sci_pkg::DW-1:0] o_section_position,
    output logic signed [sci_pkg::DW-1:0] o_section_velocity,
    output logic                          o_crossing_axis,
    output logic                          o_last_of_run
);

    localparam int DW = sci_pkg::DW;

    sci_pkg::t_bk_state r_state, n_state;
    sci_pkg::t_job r_job;
    logic          r_axis;
    logic [1:0]    r_op;
    logic [31:0]   r_count;
    logic signed [DW-1:0] r_t, r_pos, r_vel;

    logic iu_start, iu_done;
    logic signed [DW-1:0] a0, a1, c0, c1, iu_res, pos_n, vel_n;
    logic neg;

    // operand selection for current axis and operation
    always_comb begin
        c0 = (r_axis == sci_pkg::AXIS_X) ? r_job.x0 : r_job.y0;
        c1 = (r_axis == sci_pkg::AXIS_X) ? r_job.x1 : r_job.y1;
        case (r_op)
            sci_pkg::OP_TIME: begin
                a0 = r_job.t0;
                a1 = r_job.t1;
            end
            sci_pkg::OP_POS: begin
                a0 = (r_axis == sci_pkg::AXIS_X) ? r_job.y0 : r_job.x0;
                a1 = (r_axis == sci_pkg::AXIS_X) ? r_job.y1 : r_job.x1;
            end
            default: begin
                a0 = (r_axis == sci_pkg::AXIS_X) ? r_job.v0 : r_job.u0;
                a1 = (r_axis == sci_pkg::AXIS_X) ? r_job.v1 : r_job.u1;
            end
        endcase
    end

    sci_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (iu_start),
        .i_a0     (a0),
        .i_a1     (a1),
        .i_c0     (c0),
        .i_c1     (c1),
        .o_done   (iu_done),
        .o_result (iu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sci_pkg::BK_IDLE:  if (i_q_valid) n_state = sci_pkg::BK_START;
            sci_pkg::BK_START: n_state = sci_pkg::BK_WAIT;
            sci_pkg::BK_WAIT: begin
                if (iu_done) n_state = (r_op == sci_pkg::OP_VEL) ? sci_pkg::BK_OUT
                                                                  : sci_pkg::BK_START;
            end
            sci_pkg::BK_OUT: begin
                if (i_ready) n_state = (r_axis == sci_pkg::AXIS_X && r_job.keep_y)
                                       ? sci_pkg::BK_START : sci_pkg::BK_IDLE;
            end
            default: n_state = sci_pkg::BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop    = 1'b0;
        iu_start = 1'b0;
        o_valid  = 1'b0;
        case (r_state)
            sci_pkg::BK_IDLE:  o_pop    = i_q_valid;
            sci_pkg::BK_START: iu_start = 1'b1;
            sci_pkg::BK_OUT:   o_valid  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sci_pkg::BK_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) r_count <= r_count + 32'd1;
        end
    end

    // job, axis, operation and partial results
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_axis <= i_job.keep_x ? sci_pkg::AXIS_X : sci_pkg::AXIS_Y;
            r_op   <= sci_pkg::OP_TIME;
        end
        if (r_state == sci_pkg::BK_WAIT && iu_done) begin
            case (r_op)
                sci_pkg::OP_TIME: r_t   <= iu_res;
                sci_pkg::OP_POS:  r_pos <= iu_res;
                default:          r_vel <= iu_res;
            endcase
            r_op <= r_op + 2'd1;
        end
        if (o_valid && i_ready) begin
            r_axis <= sci_pkg::AXIS_Y;
            r_op   <= sci_pkg::OP_TIME;
        end
    end

    // mirroring and absolute values
    always_comb begin
        neg   = (r_axis == sci_pkg::AXIS_X) ? r_job.neg_x : r_job.neg_y;
        pos_n = neg ? sci_pkg::sat_neg(r_pos) : r_pos;
        vel_n = neg ? sci_pkg::sat_neg(r_vel) : r_vel;
        if (i_cfg.abs_pos) pos_n = sci_pkg::sat_abs(pos_n);
        if (i_cfg.abs_vel) vel_n = sci_pkg::sat_abs(vel_n);
    end

    assign o_crossing_index   = r_count;
    assign o_crossing_time    = r_t;
    assign o_section_position = pos_n;
    assign o_section_velocity = vel_n;
    assign o_crossing_axis    = r_axis;
    assign o_last_of_run      = (r_axis == sci_pkg::AXIS_Y) || !r_job.keep_y;

endmodule

>>> src/section_crossing_interpolator_core.sv
// Samples with no kept crossing are taken at one word per cycle into the front end
// while the queue is not full. Each kept crossing costs three interpolations on the
// shared bit-serial unit (issue, multiply, divide and done steps each), so its result
// word shows after all three, a second crossing of that sample after three more.
// Reset is synchronous, active low: state, count and queue clear at once,
// configuration returns to its reset values; no clearing pass is needed.
module section_crossing_interpolator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_orbit_start,
    input  logic signed [sci_pkg::DW-1:0] i_sample_time,
    input  logic signed [sci_pkg::DW-1:0] i_pos_x,
    input  logic signed [sci_pkg::DW-1:0] i_pos_y,
    input  logic signed [sci_pkg::DW-1:0] i_vel_x,
    input  logic signed [sci_pkg::DW-1:0] i_vel_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_crossing_index,
    output logic signed [sci_pkg::DW-1:0] o_crossing_time,
    output logic signed [sci_pkg::DW-1:0] o_section_position,
    output logic signed [sci_pkg::DW-1:0] o_section_velocity,
    output logic                          o_crossing_axis,
    output logic                          o_last_of_run
);

    sci_pkg::t_cfg r_cfg;
    sci_pkg::t_job push_job, head_job;
    logic push, pop, q_full, q_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_x <= 1'b0;
            r_cfg.detect_y <= 1'b1;
            r_cfg.mirror   <= 1'b1;
            r_cfg.abs_pos  <= 1'b0;
            r_cfg.abs_vel  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sci_pkg::CFG_DETECT_X: r_cfg.detect_x <= i_cfg_data;
                sci_pkg::CFG_DETECT_Y: r_cfg.detect_y <= i_cfg_data;
                sci_pkg::CFG_MIRROR:   r_cfg.mirror   <= i_cfg_data;
                sci_pkg::CFG_ABS_POS:  r_cfg.abs_pos  <= i_cfg_data;
                sci_pkg::CFG_ABS_VEL:  r_cfg.abs_vel  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sci_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_orbit_start (i_orbit_start),
        .i_sample_time (i_sample_time),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    sci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    sci_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_valid          (q_valid),
        .i_job              (head_job),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_crossing_index   (o_crossing_index),
        .o_crossing_time    (o_crossing_time),
        .o_section_position (o_section_position),
        .o_section_velocity (o_section_velocity),
        .o_crossing_axis    (o_crossing_axis),
        .o_last_of_run      (o_last_of_run)
    );

endmodule
